@@ sv/tcp_flow_session_table_macros.svh @@
// Assertion macros shared by the flow table modules.
// Each macro samples on clock and is disabled while reset is high.
`ifndef TCP_FLOW_SESSION_TABLE_MACROS_SVH
`define TCP_FLOW_SESSION_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fst_pkg.sv @@
// Types, codes and the TCP state transition function of the flow table.
// Used by all flow table modules; depends on nothing.
package fst_pkg;

   localparam int FST_ENTRIES_DEF = 64;
   localparam int FST_HANDLE_W    = 6;
   localparam int FST_FLAGS_W     = 4;

   localparam int FL_SYN_BIT = 0;
   localparam int FL_ACK_BIT = 1;
   localparam int FL_FIN_BIT = 2;
   localparam int FL_RST_BIT = 3;

   typedef enum logic [1:0] {
      OP_FIND    = 2'd0,
      OP_CREATE  = 2'd1,
      OP_DESTROY = 2'd2,
      OP_UPDATE  = 2'd3
   } fst_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_ENTRY = 2'd3
   } fst_status_type;

   typedef enum logic [1:0] {
      CONN_SYN_SENT   = 2'd0,
      CONN_ESTABLISHED = 2'd1,
      CONN_FIN_WAIT   = 2'd2,
      CONN_CLOSED     = 2'd3
   } fst_conn_type;

   typedef struct packed {
      logic                   wr_new;
      logic                   clear;
      logic                   advance;
      logic [FST_FLAGS_W-1:0] flags;
   } fst_cell_ctl_type;

   function automatic fst_conn_type fst_next_state(fst_conn_type st,
                                                    logic [FST_FLAGS_W-1:0] fl);
      fst_conn_type nxt;
      nxt = st;
      if (fl[FL_RST_BIT]) begin
         nxt = CONN_CLOSED;
      end else begin
         unique case (st)
            CONN_SYN_SENT: begin
               if (fl[FL_ACK_BIT] && !fl[FL_SYN_BIT]) nxt = CONN_ESTABLISHED;
            end
            CONN_ESTABLISHED: begin
               if (fl[FL_FIN_BIT]) nxt = CONN_FIN_WAIT;
            end
            CONN_FIN_WAIT: begin
               if (fl[FL_ACK_BIT]) nxt = CONN_CLOSED;
            end
            default: begin
               nxt = CONN_CLOSED;
            end
         endcase
      end
      return nxt;
   endfunction

endpackage

@@ sv/fst_entry.sv @@
// One flow table entry: stored tuple, connection state, valid flag and the
// forward and swapped tuple comparators. Depends on fst_pkg.
module fst_entry
   import fst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fst_cell_ctl_type ctl,
   input  logic [31:0]      src_addr,
   input  logic [31:0]      dst_addr,
   input  logic [15:0]      pkt_sport,
   input  logic [15:0]      pkt_dport,
   output logic             valid,
   output logic             fwd_hit,
   output logic             rev_hit,
   output fst_conn_type     conn_state
);

   logic         valid_ff, valid_in;
   logic [31:0]  src_ff;
   logic [31:0]  dst_ff;
   logic [31:0]  ports_ff;
   fst_conn_type state_ff, state_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_new) begin
         valid_in = 1'b1;
      end else if (ctl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (ctl.wr_new) begin
         state_in = CONN_SYN_SENT;
      end else if (ctl.advance) begin
         state_in = fst_next_state(state_ff, ctl.flags);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (ctl.wr_new) begin
         src_ff   <= src_addr;
         dst_ff   <= dst_addr;
         ports_ff <= {pkt_sport, pkt_dport};
      end
   end

   assign valid      = valid_ff;
   assign conn_state = state_ff;
   assign fwd_hit    = valid_ff && (src_ff == src_addr) && (dst_ff == dst_addr) &&
                       (ports_ff == {pkt_sport, pkt_dport});
   assign rev_hit    = valid_ff && (src_ff == dst_addr) && (dst_ff == src_addr) &&
                       (ports_ff == {pkt_dport, pkt_sport});

endmodule

@@ sv/fst_first.sv @@
// Lowest set bit finder: isolates the lowest set request bit and encodes it.
// Depends on fst_pkg for its parameter defaults.
module fst_first
   import fst_pkg::*;
#(
   parameter int N  = FST_ENTRIES_DEF,
   parameter int IW = $clog2(FST_ENTRIES_DEF)
) (
   input  logic [N-1:0]  req_vec,
   output logic          found,
   output logic [N-1:0]  first_onehot,
   output logic [IW-1:0] first_index
);

   assign found        = |req_vec;
   assign first_onehot = req_vec & ((~req_vec) + {{(N-1){1'b0}}, 1'b1});

   always_comb begin
      logic [31:0] pos;
      first_index = '0;
      for (int i = 0; i < N; i++) begin
         pos = 32'(i);
         for (int b = 0; b < IW; b++) begin
            if (pos[b]) first_index[b] = first_index[b] | first_onehot[i];
         end
      end
   end

endmodule

@@ sv/tcp_flow_session_table.sv @@
// TCP flow table: one operation per transfer, result through the request and then the result register.
// A new item is taken every cycle and the receiver cannot stall; busy is always
// low, so throughput is one item per cycle, set by the parallel compare.
// Synchronous reset empties the table and drops any item in flight.
// Entry tuples and states are not reset; only valid entries are ever read.
module tcp_flow_session_table
   import fst_pkg::*;
#(
   parameter int TABLE_ENTRIES = FST_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_opcode,
   input  logic [31:0]             req_src_addr,
   input  logic [31:0]             req_dst_addr,
   input  logic [15:0]             req_src_port,
   input  logic [15:0]             req_dst_port,
   input  logic [FST_HANDLE_W-1:0] req_entry_index,
   input  logic [FST_FLAGS_W-1:0]  req_tcp_flags,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [FST_HANDLE_W-1:0] rsp_result_index,
   output logic [1:0]              rsp_conn_state,
   output logic                    rsp_reversed_match
);

`include "tcp_flow_session_table_macros.svh"

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic                    req_vld_ff;
   fst_op_type              op_ff;
   logic [31:0]             sa_ff;
   logic [31:0]             da_ff;
   logic [15:0]             sp_ff;
   logic [15:0]             dp_ff;
   logic [FST_HANDLE_W-1:0] idx_ff;
   logic [FST_FLAGS_W-1:0]  flags_ff;

   logic [TABLE_ENTRIES-1:0] cell_valid;
   logic [TABLE_ENTRIES-1:0] cell_fwd;
   logic [TABLE_ENTRIES-1:0] cell_rev;
   logic [TABLE_ENTRIES-1:0] idx_hit;
   fst_conn_type             cell_state [TABLE_ENTRIES];
   fst_cell_ctl_type         cell_ctl [TABLE_ENTRIES];

   logic                     fwd_any, rev_any, free_any;
   logic [TABLE_ENTRIES-1:0] fwd_one, rev_one, free_one;
   logic [IDX_W-1:0]         fwd_idx, rev_idx, free_idx;
   logic [1:0]               fwd_st, rev_st, idx_st;
   logic                     handle_ok;
   logic                     do_create, do_destroy, do_update;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   fst_status_type          rsp_status_ff, rsp_status_in;
   logic [FST_HANDLE_W-1:0] rsp_index_ff, rsp_index_in;
   fst_conn_type            rsp_state_ff, rsp_state_in;
   logic                    rsp_rev_ff, rsp_rev_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= fst_op_type'(req_opcode);
      sa_ff    <= req_src_addr;
      da_ff    <= req_dst_addr;
      sp_ff    <= req_src_port;
      dp_ff    <= req_dst_port;
      idx_ff   <= req_entry_index;
      flags_ff <= req_tcp_flags;
   end

   assign do_create  = req_vld_ff && (op_ff == OP_CREATE) && free_any;
   assign do_destroy = req_vld_ff && (op_ff == OP_DESTROY);
   assign do_update  = req_vld_ff && (op_ff == OP_UPDATE);

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      assign idx_hit[i]          = (32'(idx_ff) == 32'(i));
      assign cell_ctl[i].wr_new  = do_create && free_one[i];
      assign cell_ctl[i].clear   = do_destroy && idx_hit[i] && cell_valid[i];
      assign cell_ctl[i].advance = do_update && idx_hit[i] && cell_valid[i];
      assign cell_ctl[i].flags   = flags_ff;

      fst_entry u_entry (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .src_addr   (sa_ff),
         .dst_addr   (da_ff),
         .pkt_sport  (sp_ff),
         .pkt_dport  (dp_ff),
         .valid      (cell_valid[i]),
         .fwd_hit    (cell_fwd[i]),
         .rev_hit    (cell_rev[i]),
         .conn_state (cell_state[i])
      );
   end

   fst_first #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_first_fwd (
      .req_vec      (cell_fwd),
      .found        (fwd_any),
      .first_onehot (fwd_one),
      .first_index  (fwd_idx)
   );

   fst_first #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_first_rev (
      .req_vec      (cell_rev),
      .found        (rev_any),
      .first_onehot (rev_one),
      .first_index  (rev_idx)
   );

   fst_first #(.N(TABLE_ENTRIES), .IW(IDX_W)) u_first_free (
      .req_vec      (~cell_valid),
      .found        (free_any),
      .first_onehot (free_one),
      .first_index  (free_idx)
   );

   assign handle_ok = |(idx_hit & cell_valid);

   always_comb begin
      fwd_st = '0;
      rev_st = '0;
      idx_st = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         fwd_st = fwd_st | ({2{fwd_one[i]}} & 2'(cell_state[i]));
         rev_st = rev_st | ({2{rev_one[i]}} & 2'(cell_state[i]));
         idx_st = idx_st | ({2{idx_hit[i]}} & 2'(cell_state[i]));
      end
   end

   always_comb begin
      rsp_strobe_in = req_vld_ff;
      rsp_status_in = ST_OK;
      rsp_index_in  = idx_ff;
      rsp_state_in  = CONN_CLOSED;
      rsp_rev_in    = 1'b0;
      unique case (op_ff)
         OP_FIND: begin
            if (fwd_any) begin
               rsp_index_in = FST_HANDLE_W'(fwd_idx);
               rsp_state_in = fst_conn_type'(fwd_st);
            end else if (rev_any) begin
               rsp_index_in = FST_HANDLE_W'(rev_idx);
               rsp_state_in = fst_conn_type'(rev_st);
               rsp_rev_in   = 1'b1;
            end else begin
               rsp_status_in = ST_NOT_FOUND;
               rsp_index_in  = '0;
            end
         end
         OP_CREATE: begin
            if (free_any) begin
               rsp_index_in = FST_HANDLE_W'(free_idx);
               rsp_state_in = CONN_SYN_SENT;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_DESTROY: begin
            if (!handle_ok) rsp_status_in = ST_BAD_ENTRY;
         end
         OP_UPDATE: begin
            if (handle_ok) begin
               rsp_state_in = fst_next_state(fst_conn_type'(idx_st), flags_ff);
            end else begin
               rsp_status_in = ST_BAD_ENTRY;
            end
         end
         default: begin
            rsp_status_in = ST_BAD_ENTRY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_rev_ff    <= rsp_rev_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_conn_state     = rsp_state_ff;
   assign rsp_reversed_match = rsp_rev_ff;

   `FST_ASSERT_NEXT(a_rsp_follows_req, req_vld_ff, rsp_strobe_ff,
      "accepted transfer produced no result")
   `FST_ASSERT_SAME(a_rev_only_on_ok, rsp_strobe_ff && rsp_rev_ff,
      (rsp_status_ff == ST_OK),
      "swapped match reported on a failed find")
   `FST_ASSERT_NEXT(a_create_fills_one, do_create,
      ($countones(cell_valid) == $past($countones(cell_valid)) + 1),
      "create did not fill exactly one entry")
   `FST_ASSERT_NEXT(a_destroy_frees_one, do_destroy && handle_ok,
      ($countones(cell_valid) + 1 == $past($countones(cell_valid))),
      "destroy did not free exactly one entry")
   `FST_ASSERT_SAME(a_single_first_hit, req_vld_ff,
      ($onehot0(fwd_one) && $onehot0(rev_one) && $onehot0(free_one)),
      "more than one entry selected")

endmodule
